// ===== rtl/core/bat_pkg.sv =====
// Shared types, codes and helpers for the broadcast acknowledge tracker.
// No dependencies; every other file of the block imports this package.
package bat_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int MAX_CLUSTER_COUNT = 32;
  localparam int CLUSTER_CAP       = (MAX_CLUSTER_COUNT < 32) ? MAX_CLUSTER_COUNT : 32;
  localparam int LINE_OFFSET_MAX   = 12;

  localparam logic CFG_CLUSTER_CNT = 1'b0;
  localparam logic CFG_LINE_OFFSET = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ACK    = 2'd1,
    OP_READ   = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_ENTRY    = 3'd1,
    ST_DUPLICATE   = 3'd2,
    ST_ACKED       = 3'd3,
    ST_FULL        = 3'd4,
    ST_BAD_CLUSTER = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] word;
    logic [31:0] seen;
    logic [31:0] acked;
    logic [5:0]  count;
  } entry_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] bcast_word;
    logic        from_broadcast;
    logic        mem_write_valid;
    logic [31:0] mem_write_address;
    logic [31:0] mem_write_word;
  } result_t;

  typedef struct packed {
    logic [5:0]  active;
    logic [31:0] line_keep;
  } cfg_t;

  function automatic logic [5:0] active_clusters(logic [5:0] n);
    logic [5:0] r;
    r = n;
    if (n == 6'd0) r = 6'd1;
    else if (n > 6'(CLUSTER_CAP)) r = 6'(CLUSTER_CAP);
    return r;
  endfunction

  function automatic logic [31:0] line_keep_mask(logic [3:0] off);
    logic [3:0] b;
    b = (off > 4'(LINE_OFFSET_MAX)) ? 4'(LINE_OFFSET_MAX) : off;
    return 32'hFFFF_FFFF << b;
  endfunction

endpackage

// ===== rtl/core/broadcast_ack_tracker_top.sv =====
// Broadcast acknowledge tracker: one request at a time through a table scan.
// A request with an unused opcode or an inactive cluster skips the scan; others
// read every table entry before the result is formed. A new request is taken
// only after the result of the last one has moved into the output register.
// Reset clears the entry valid flags, the sequencer and the output register and
// loads an active cluster count of 32 and a line offset of 5; table data stays.
module broadcast_ack_tracker_top
  import bat_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // opcode
  input  logic [71:0]  in_tdata,   // address, new_word, cluster_id, zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [2:0]   out_tuser,  // status
  output logic [103:0] out_tdata,  // bcast_word, from_broadcast, mem_write_valid,
                                   // mem_write_address, mem_write_word, zero pad
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [5:0]   cfg_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [5:0] cluster_cnt_r;
  logic [3:0] line_offset_r;
  cfg_t       cfg;

  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  entry_t           mem_rd_data;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  entry_t           mem_wr_data;
  logic             res_valid;
  logic             res_ready;
  result_t          res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cluster_cnt_r <= 6'd32;
      line_offset_r <= 4'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLUSTER_CNT: cluster_cnt_r <= cfg_data;
        CFG_LINE_OFFSET: line_offset_r <= cfg_data[3:0];
      endcase
    end
  end

  always_comb begin
    cfg.active    = active_clusters(cluster_cnt_r);
    cfg.line_keep = line_keep_mask(line_offset_r);
  end

  bat_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (opcode_t'(in_tuser)),
    .in_addr    (in_tdata[31:0]),
    .in_word    (in_tdata[63:32]),
    .in_cl      (in_tdata[68:64]),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  bat_mem #(
    .DEPTH(TABLE_ENTRIES),
    .AW   (IDX_W)
  ) u_mem (
    .clk    (clk),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data)
  );

  bat_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(res_valid),
    .push_ready(res_ready),
    .push_res  (res),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

endmodule

// ===== rtl/core/bat_mem.sv =====
// Entry store of the tracker: one write port, one registered read port.
// Depends on bat_pkg for the entry layout.
module bat_mem
  import bat_pkg::*;
#(
  parameter int DEPTH = TABLE_ENTRIES_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem_r [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/bat_ctrl.sv =====
// Request sequencer: scans the entry store, resolves the request, writes back.
// Depends on bat_pkg; drives bat_mem and feeds the output register.
module bat_ctrl
  import bat_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  parameter int CNT_W         = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  opcode_t          in_op,
  input  logic [31:0]      in_addr,
  input  logic [31:0]      in_word,
  input  logic [4:0]       in_cl,
  output logic             mem_rd_en,
  output logic [IDX_W-1:0] mem_rd_addr,
  input  entry_t           mem_rd_data,
  output logic             mem_wr_en,
  output logic [IDX_W-1:0] mem_wr_addr,
  output entry_t           mem_wr_data,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res
);

  state_t state_r, state_nxt;

  opcode_t          op_r;
  logic [31:0]      addr_r;
  logic [31:0]      word_r;
  logic [4:0]       cl_r;
  logic [CNT_W-1:0] iss_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             hit_found_r;
  logic [IDX_W-1:0] hit_idx_r;
  entry_t           hit_ent_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             valid_r [TABLE_ENTRIES];
  result_t          res_r;

  logic    accept;
  logic    early;
  result_t early_res;
  logic    match;
  logic    cur_valid;
  logic    last_cmp;

  logic             [31:0] bit_sel;
  logic             [5:0]  cnt_inc;
  result_t          upd_res;
  logic             upd_we;
  logic [IDX_W-1:0] upd_idx;
  entry_t           upd_data;
  logic             upd_set;
  logic             upd_clr;

  assign accept = in_valid && in_ready;
  assign early  = (in_op == OP_UNUSED) || ({1'b0, in_cl} >= cfg.active);

  always_comb begin
    early_res        = '0;
    early_res.status = (in_op == OP_UNUSED) ? ST_NO_ENTRY : ST_BAD_CLUSTER;
  end

  // Reads compare the exact byte address, insert and acknowledge the line.
  assign match = (op_r == OP_READ) ? (mem_rd_data.addr == addr_r)
                                   : ((mem_rd_data.addr & cfg.line_keep) ==
                                      (addr_r & cfg.line_keep));
  assign cur_valid = valid_r[rd_idx_r];
  assign last_cmp  = rd_vld_r && (rd_idx_r == IDX_W'(TABLE_ENTRIES - 1));

  assign bit_sel = 32'd1 << cl_r;
  assign cnt_inc = (hit_ent_r.count == 6'd63) ? 6'd63 : hit_ent_r.count + 6'd1;

  always_comb begin
    upd_res  = '0;
    upd_we   = 1'b0;
    upd_idx  = hit_idx_r;
    upd_data = hit_ent_r;
    upd_set  = 1'b0;
    upd_clr  = 1'b0;
    unique case (op_r)
      OP_INSERT: begin
        if (hit_found_r) begin
          upd_res.status = ST_DUPLICATE;
        end else if (!free_found_r) begin
          upd_res.status = ST_FULL;
        end else begin
          upd_res.status = ST_OK;
          upd_we         = 1'b1;
          upd_set        = 1'b1;
          upd_idx        = free_idx_r;
          upd_data.addr  = addr_r;
          upd_data.word  = word_r;
          upd_data.seen  = bit_sel;
          upd_data.acked = '0;
          upd_data.count = '0;
        end
      end
      OP_ACK: begin
        if (!hit_found_r) begin
          upd_res.status = ST_NO_ENTRY;
        end else if ((hit_ent_r.acked & bit_sel) != '0) begin
          upd_res.status = ST_ACKED;
        end else begin
          upd_res.status = ST_OK;
          upd_we         = 1'b1;
          upd_data.seen  = hit_ent_r.seen | bit_sel;
          upd_data.acked = hit_ent_r.acked | bit_sel;
          upd_data.count = cnt_inc;
          // Free the entry once enough clusters have acknowledged.
          if (cnt_inc >= cfg.active) begin
            upd_clr                   = 1'b1;
            upd_res.mem_write_valid   = 1'b1;
            upd_res.mem_write_address = hit_ent_r.addr;
            upd_res.mem_write_word    = hit_ent_r.word;
          end
        end
      end
      OP_READ: begin
        if (!hit_found_r) begin
          upd_res.status = ST_NO_ENTRY;
        end else if ((hit_ent_r.seen & bit_sel) != '0) begin
          upd_res.status         = ST_OK;
          upd_res.bcast_word     = hit_ent_r.word;
          upd_res.from_broadcast = 1'b1;
        end else begin
          upd_res.status = ST_OK;
        end
      end
      OP_UNUSED: begin
        upd_res.status = ST_NO_ENTRY;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = early ? S_EMIT : S_SCAN;
      S_SCAN:   if (last_cmp) state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_EMIT;
      S_EMIT:   if (res_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == S_IDLE);
    mem_rd_en   = (state_r == S_SCAN) && (iss_r < CNT_W'(TABLE_ENTRIES));
    mem_rd_addr = iss_r[IDX_W-1:0];
    mem_wr_en   = (state_r == S_UPDATE) && upd_we;
    mem_wr_addr = upd_idx;
    mem_wr_data = upd_data;
    res_valid   = (state_r == S_EMIT);
    res         = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      iss_r        <= '0;
      rd_vld_r     <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) valid_r[i] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        iss_r        <= '0;
        rd_vld_r     <= 1'b0;
        hit_found_r  <= 1'b0;
        free_found_r <= 1'b0;
      end
      if (state_r == S_SCAN) begin
        rd_vld_r <= mem_rd_en;
        if (mem_rd_en) iss_r <= iss_r + CNT_W'(1);
        if (rd_vld_r && cur_valid && match) hit_found_r <= 1'b1;
        if (rd_vld_r && !cur_valid) free_found_r <= 1'b1;
      end
      if (state_r == S_UPDATE) begin
        if (upd_set) valid_r[upd_idx] <= 1'b1;
        if (upd_clr) valid_r[upd_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      addr_r <= in_addr;
      word_r <= in_word;
      cl_r   <= in_cl;
      if (early) res_r <= early_res;
    end
    if (state_r == S_SCAN) begin
      rd_idx_r <= iss_r[IDX_W-1:0];
      // Keep the lowest matching entry and the lowest free slot.
      if (rd_vld_r && cur_valid && match && !hit_found_r) begin
        hit_idx_r <= rd_idx_r;
        hit_ent_r <= mem_rd_data;
      end
      if (rd_vld_r && !cur_valid && !free_found_r) free_idx_r <= rd_idx_r;
    end
    if (state_r == S_UPDATE) res_r <= upd_res;
  end

endmodule

// ===== rtl/core/bat_outq.sv =====
// Output register of the tracker: holds one result until the sink takes it.
// Depends on bat_pkg for the result layout.
module bat_outq
  import bat_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  result_t       push_res,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [2:0]    out_tuser,
  output logic [103:0]  out_tdata
);

  logic    valid_r;
  result_t res_r;

  assign push_ready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push_ready) begin
      valid_r <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ready && push_valid) res_r <= push_res;
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {6'd0,
                       res_r.mem_write_word,
                       res_r.mem_write_address,
                       res_r.mem_write_valid,
                       res_r.from_broadcast,
                       res_r.bcast_word};

endmodule

// ===== rtl/core/bat_checker.sv =====
// Port-level checks for the broadcast acknowledge tracker, bound to the top.
// Depends on bat_pkg for the status codes.
module bat_checker
  import bat_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [2:0]   out_tuser,
  input logic [103:0] out_tdata
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Only one request is in flight.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= 3'(ST_BAD_CLUSTER))
    else $error("status code out of range");

  a_read_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tuser == ST_OK && !out_tdata[33])
    else $error("read data flagged with a bad status or a memory write");

  a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33] |-> out_tuser == ST_OK && out_tdata[32:0] == 33'd0)
    else $error("memory write combined with read data or a bad status");

endmodule

bind broadcast_ack_tracker_top bat_checker u_bat_checker (.*);
